// ----- rtl/core/multi_lane_race_finish_timer_defines.svh -----
// Assertion macros for the race finish timer checker.
// Included by mlrft_checker.sv; needs clk and arst_n in scope.
`ifndef MULTI_LANE_RACE_FINISH_TIMER_DEFINES_SVH
`define MULTI_LANE_RACE_FINISH_TIMER_DEFINES_SVH

// same-cycle implication
`define MLRFT_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mlrft check failed");

// next-cycle implication
`define MLRFT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mlrft check failed");

`endif

// ----- rtl/core/mlrft_pkg.sv -----
// Shared types and constants for the multi-lane race finish timer.
// No dependencies.
`timescale 1ns / 1ps

package mlrft_pkg;

	localparam int LANES_DEF     = 8;
	localparam int TIME_BITS_DEF = 32;
	localparam int LANE_CNT_RST  = 8;

	typedef enum logic [2:0] {
		CMD_TICK  = 3'd0,
		CMD_RESET = 3'd1,
		CMD_ARM   = 3'd2,
		CMD_GATE  = 3'd3,
		CMD_EDGE  = 3'd4,
		CMD_POLL  = 3'd5,
		CMD_READ  = 3'd6
	} cmd_t;

	typedef enum logic [3:0] {
		PH_RESET = 4'b0001,
		PH_SET   = 4'b0010,
		PH_RACE  = 4'b0100,
		PH_DONE  = 4'b1000
	} phase_t;

	// phase codes as seen on the result channel
	localparam logic [1:0] PHC_RESET = 2'd0;
	localparam logic [1:0] PHC_SET   = 2'd1;
	localparam logic [1:0] PHC_RACE  = 2'd2;
	localparam logic [1:0] PHC_DONE  = 2'd3;

	typedef struct packed {
		logic [1:0]  phase;
		logic        accepted;
		logic [31:0] start_time;
		logic [31:0] lane_time;
		logic        lane_done;
	} res_t;

endpackage

// ----- rtl/core/mlrft_core.sv -----
// Timer state and per-item update: counter, phase, start and lane capture, lane count.
// Depends on mlrft_pkg.
`timescale 1ns / 1ps

module mlrft_core #(
	parameter int LANES     = mlrft_pkg::LANES_DEF,
	parameter int TIME_BITS = mlrft_pkg::TIME_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [2:0]        cmd,
	input  logic [2:0]        lane,
	input  logic              gate_closed,
	input  logic              cfg_we,
	input  logic [3:0]        cfg_data,
	output mlrft_pkg::res_t   res
);

	localparam int CNT_W   = $clog2(LANES + 1);
	localparam int CNT_RST = (LANES < mlrft_pkg::LANE_CNT_RST) ? LANES : mlrft_pkg::LANE_CNT_RST;

	mlrft_pkg::phase_t      phase_q, phase_d;
	logic [TIME_BITS-1:0]   count_q, count_d;
	logic [TIME_BITS-1:0]   start_q, start_d;
	logic [TIME_BITS-1:0]   times_q [LANES];
	logic [LANES-1:0]       flags_q, flags_d;
	logic [LANES-1:0]       sel;
	logic [LANES-1:0]       wr;
	logic [CNT_W-1:0]       lane_count_q;
	logic                   all_done;
	logic                   acc;
	logic [TIME_BITS-1:0]   sel_time;
	logic [1:0]             phase_code;

	always_comb begin
		all_done = 1'b1;
		for (int i = 0; i < LANES; i++) begin
			sel[i] = (int'(lane) == i);
			if (i < int'(lane_count_q) && !flags_q[i])
				all_done = 1'b0;
		end
	end

	always_comb begin
		phase_d = phase_q;
		count_d = count_q;
		start_d = start_q;
		flags_d = flags_q;
		wr      = '0;
		acc     = 1'b0;
		unique case (mlrft_pkg::cmd_t'(cmd))
			mlrft_pkg::CMD_TICK: count_d = count_q + TIME_BITS'(1);
			mlrft_pkg::CMD_RESET: begin
				phase_d = mlrft_pkg::PH_RESET;
				start_d = '0;
				flags_d = '0;
			end
			mlrft_pkg::CMD_ARM: begin
				if (phase_q == mlrft_pkg::PH_RESET) begin
					phase_d = mlrft_pkg::PH_SET;
					acc     = 1'b1;
				end
			end
			mlrft_pkg::CMD_GATE: begin
				if (phase_q == mlrft_pkg::PH_SET) begin
					phase_d = mlrft_pkg::PH_RACE;
					start_d = count_q;
					flags_d = '0;
				end
			end
			mlrft_pkg::CMD_EDGE: begin
				// first edge per lane wins
				wr      = sel & ~flags_q;
				flags_d = flags_q | sel;
			end
			mlrft_pkg::CMD_POLL: begin
				if (phase_q == mlrft_pkg::PH_RESET && gate_closed)
					phase_d = mlrft_pkg::PH_SET;
				else if (phase_q == mlrft_pkg::PH_RACE && all_done)
					phase_d = mlrft_pkg::PH_DONE;
			end
			default: ;
		endcase
	end

	// report the selected lane as it stands after this item
	always_comb begin
		sel_time = '0;
		for (int i = 0; i < LANES; i++) begin
			if (sel[i] && flags_d[i])
				sel_time = sel_time | (wr[i] ? count_q : times_q[i]);
		end
	end

	always_comb begin
		unique case (phase_d)
			mlrft_pkg::PH_RESET: phase_code = mlrft_pkg::PHC_RESET;
			mlrft_pkg::PH_SET:   phase_code = mlrft_pkg::PHC_SET;
			mlrft_pkg::PH_RACE:  phase_code = mlrft_pkg::PHC_RACE;
			mlrft_pkg::PH_DONE:  phase_code = mlrft_pkg::PHC_DONE;
			default:             phase_code = mlrft_pkg::PHC_RESET;
		endcase
	end

	assign res.phase      = phase_code;
	assign res.accepted   = acc;
	assign res.start_time = 32'(start_d);
	assign res.lane_time  = 32'(sel_time);
	assign res.lane_done  = |(sel & flags_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= mlrft_pkg::PH_RESET;
			count_q <= '0;
			start_q <= '0;
			flags_q <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			count_q <= count_d;
			start_q <= start_d;
			flags_q <= flags_d;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < LANES; i++) begin
			if (step && wr[i])
				times_q[i] <= count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lane_count_q <= CNT_W'(CNT_RST);
		end else if (cfg_we) begin
			if (cfg_data == 4'd0)
				lane_count_q <= CNT_W'(1);
			else if (int'(cfg_data) > LANES)
				lane_count_q <= CNT_W'(LANES);
			else
				lane_count_q <= CNT_W'(cfg_data);
		end
	end

endmodule

// ----- rtl/core/mlrft_outbuf.sv -----
// Result register with a skid entry, so in_ready never depends combinationally on out_ready.
// Depends on mlrft_pkg.
`timescale 1ns / 1ps

module mlrft_outbuf (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  mlrft_pkg::res_t push_data,
	output logic            buf_ready,
	output logic            out_valid,
	input  logic            out_ready,
	output mlrft_pkg::res_t out_data
);

	logic            out_v_q;
	logic            skid_v_q;
	mlrft_pkg::res_t out_q;
	mlrft_pkg::res_t skid_q;
	logic            take;

	assign take      = out_v_q && out_ready;
	assign buf_ready = !skid_v_q;
	assign out_valid = out_v_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (push) begin
				if (!out_v_q || take)
					out_v_q <= 1'b1;
				else
					skid_v_q <= 1'b1;
			end else if (take) begin
				out_v_q  <= skid_v_q;
				skid_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push && (!out_v_q || take))
			out_q <= push_data;
		else if (push)
			skid_q <= push_data;
		else if (take && skid_v_q)
			out_q <= skid_q;
	end

endmodule

// ----- rtl/core/multi_lane_race_finish_timer.sv -----
// Top level of the multi-lane race finish timer.
// Depends on mlrft_pkg, mlrft_core, mlrft_outbuf.
//
// channel  direction  handshake             payload
// in       input      in_valid / in_ready   cmd, lane, gate_closed
// out      output     out_valid / out_ready phase, accepted, start_time, lane_time, lane_done
// cfg      input      cfg_valid / cfg_ready cfg_data (lane_count)
//
// One item per cycle sustained while the result side keeps up; an accepted item passes
// the input register, then the state update into the result register, before its result is valid.
// Reset clears phase, counter, start time, lane flags and the handshake state.
// The result side has a skid entry: in_ready drops only once two results wait.
// cfg_ready is always high; a write is registered into the lane count.
`timescale 1ns / 1ps

module multi_lane_race_finish_timer #(
	parameter int LANES     = mlrft_pkg::LANES_DEF,
	parameter int TIME_BITS = mlrft_pkg::TIME_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  cmd,
	input  logic [2:0]  lane,
	input  logic        gate_closed,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  phase,
	output logic        accepted,
	output logic [31:0] start_time,
	output logic [31:0] lane_time,
	output logic        lane_done,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_data
);

	logic            valid_s1;
	logic [2:0]      cmd_s1;
	logic [2:0]      lane_s1;
	logic            gate_s1;
	logic            buf_ready;
	logic            step;
	mlrft_pkg::res_t res;
	mlrft_pkg::res_t out_res;

	assign step      = valid_s1 && buf_ready;
	assign in_ready  = !valid_s1 || buf_ready;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ready)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1  <= cmd;
			lane_s1 <= lane;
			gate_s1 <= gate_closed;
		end
	end

	mlrft_core #(
		.LANES     (LANES),
		.TIME_BITS (TIME_BITS)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.cmd         (cmd_s1),
		.lane        (lane_s1),
		.gate_closed (gate_s1),
		.cfg_we      (cfg_valid && cfg_ready),
		.cfg_data    (cfg_data),
		.res         (res)
	);

	mlrft_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (step),
		.push_data (res),
		.buf_ready (buf_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_res)
	);

	assign phase      = out_res.phase;
	assign accepted   = out_res.accepted;
	assign start_time = out_res.start_time;
	assign lane_time  = out_res.lane_time;
	assign lane_done  = out_res.lane_done;

endmodule

// ----- rtl/core/mlrft_checker.sv -----
// Port-level checks for the race finish timer, bound to the top level.
// Depends on multi_lane_race_finish_timer_defines.svh and mlrft_pkg.
`timescale 1ns / 1ps
`include "multi_lane_race_finish_timer_defines.svh"

module mlrft_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  phase,
	input logic        accepted,
	input logic [31:0] start_time,
	input logic [31:0] lane_time,
	input logic        lane_done
);

	// stalled result holds
	`MLRFT_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(phase) && $stable(start_time) && $stable(lane_time))
	// an accepted arm always leaves the timer in the set phase
	`MLRFT_ASSERT_NOW(a_arm_set, out_valid && accepted, phase == mlrft_pkg::PHC_SET)
	// an unfinished lane reports zero time
	`MLRFT_ASSERT_NOW(a_lane_zero, out_valid && !lane_done, lane_time == 32'd0)
	// input only backs up behind a waiting result
	`MLRFT_ASSERT_NOW(a_backpressure, !in_ready, out_valid)

endmodule

bind multi_lane_race_finish_timer mlrft_checker u_mlrft_checker (.*);

// ----- sim/multi_lane_race_finish_timer_tb.sv -----
// Self-checking testbench for multi_lane_race_finish_timer: a queued driver, a ready
// generator and a monitor checked against a cycle-free model of the race timer.
// Depends on mlrft_pkg and the RTL under rtl/core.
`timescale 1ns / 1ps

module multi_lane_race_finish_timer_tb;

	localparam logic [2:0] CMD_NONE = 3'd7;	// unused code, must change nothing
	localparam int LONG_HOLD = 300;
	localparam int PHASE_ITEMS = 100;

	typedef struct packed {
		logic [2:0] cmd;
		logic [2:0] lane;
		logic       gate;
	} race_item_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [2:0]  cmd = 3'd0;
	logic [2:0]  lane = 3'd0;
	logic        gate_closed = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  phase;
	logic        accepted;
	logic [31:0] start_time;
	logic [31:0] lane_time;
	logic        lane_done;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [3:0]  cfg_data = 4'd0;

	// timer model state
	logic [1:0]  race_phase = mlrft_pkg::PHC_RESET;
	logic [31:0] us_count = '0;
	logic [31:0] start_cap = '0;
	logic [31:0] lane_fin [mlrft_pkg::LANES_DEF];
	logic [7:0]  lane_hit = '0;
	int          lanes_used = mlrft_pkg::LANE_CNT_RST;

	race_item_t       cmd_q [$];
	mlrft_pkg::res_t  timer_res_q [$];
	race_item_t       cur_item;
	mlrft_pkg::res_t  res_want;

	int send_idle_pct = 0;
	int ready_stall_pct = 0;
	int hold_kick = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int items_taken = 0;
	int results_seen = 0;
	int races_done = 0;
	int cfg_writes = 0;
	int errors = 0;

	int lane_sets [6] = '{15, 3, 1, 8, 2, 5};
	int send_rates [6] = '{0, 58, 0, 38, 0, 38};
	int ready_rates [6] = '{0, 0, 58, 38, 0, 38};

	multi_lane_race_finish_timer i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.cmd        (cmd),
		.lane       (lane),
		.gate_closed(gate_closed),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.phase      (phase),
		.accepted   (accepted),
		.start_time (start_time),
		.lane_time  (lane_time),
		.lane_done  (lane_done),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#(12 * 400000);
		$display("timeout: %0d items taken, %0d results seen", items_taken, results_seen);
		$display("*** FAILED ***");
		$finish;
	end

	function automatic void clear_lanes();
		lane_hit = '0;
		foreach (lane_fin[i]) lane_fin[i] = '0;
	endfunction

	// apply one item to the model, return the result it must produce
	function automatic mlrft_pkg::res_t race_step(input race_item_t it);
		mlrft_pkg::res_t r;
		logic arm_ok;
		logic all_in;
		arm_ok = 1'b0;
		case (it.cmd)
			mlrft_pkg::CMD_TICK: us_count = us_count + 32'd1;
			mlrft_pkg::CMD_RESET: begin
				race_phase = mlrft_pkg::PHC_RESET;
				start_cap = '0;
				clear_lanes();
			end
			mlrft_pkg::CMD_ARM: begin
				if (race_phase == mlrft_pkg::PHC_RESET) begin
					race_phase = mlrft_pkg::PHC_SET;
					arm_ok = 1'b1;
				end
			end
			mlrft_pkg::CMD_GATE: begin
				if (race_phase == mlrft_pkg::PHC_SET) begin
					start_cap = us_count;
					clear_lanes();
					race_phase = mlrft_pkg::PHC_RACE;
				end
			end
			mlrft_pkg::CMD_EDGE: begin
				// lane edges count in any phase, first one only
				if (!lane_hit[it.lane]) begin
					lane_fin[it.lane] = us_count;
					lane_hit[it.lane] = 1'b1;
				end
			end
			mlrft_pkg::CMD_POLL: begin
				all_in = 1'b1;
				for (int i = 0; i < lanes_used; i++)
					if (!lane_hit[i]) all_in = 1'b0;
				if (race_phase == mlrft_pkg::PHC_RESET && it.gate) begin
					race_phase = mlrft_pkg::PHC_SET;
				end else if (race_phase == mlrft_pkg::PHC_RACE && all_in) begin
					race_phase = mlrft_pkg::PHC_DONE;
					races_done++;
				end
			end
			default: ;
		endcase
		r.phase = race_phase;
		r.accepted = arm_ok;
		r.start_time = start_cap;
		r.lane_done = lane_hit[it.lane];
		r.lane_time = lane_hit[it.lane] ? lane_fin[it.lane] : 32'd0;
		return r;
	endfunction

	function automatic void add_item(input logic [2:0] c, input logic [2:0] l, input logic g);
		race_item_t it;
		it.cmd = c;
		it.lane = l;
		it.gate = g;
		cmd_q.push_back(it);
	endfunction

	function automatic logic [2:0] any_lane();
		return 3'($urandom_range(7));
	endfunction

	// one race: an optional reset, arm, start, lanes finishing in random order, polls and reads
	function automatic void queue_race();
		logic [2:0] order [8];
		logic [2:0] t;
		int n;
		int k;
		for (int j = 0; j < 8; j++) order[j] = 3'(j);
		for (int j = 7; j > 0; j--) begin
			k = $urandom_range(j);
			t = order[j];
			order[j] = order[k];
			order[k] = t;
		end
		if ($urandom_range(9) < 8)
			add_item(mlrft_pkg::CMD_RESET, any_lane(), 1'($urandom_range(1)));
		if ($urandom_range(1)) add_item(mlrft_pkg::CMD_ARM, any_lane(), 1'($urandom_range(1)));
		else add_item(mlrft_pkg::CMD_POLL, any_lane(), 1'b1);
		repeat ($urandom_range(3))
			add_item(mlrft_pkg::CMD_TICK, any_lane(), 1'($urandom_range(1)));
		if ($urandom_range(7) == 0) add_item(mlrft_pkg::CMD_EDGE, any_lane(), 1'b0);
		add_item(mlrft_pkg::CMD_GATE, any_lane(), 1'($urandom_range(1)));
		n = ($urandom_range(9) < 7) ? 8 : $urandom_range(1, 8);
		for (int j = 0; j < n; j++) begin
			repeat ($urandom_range(4))
				add_item(mlrft_pkg::CMD_TICK, any_lane(), 1'($urandom_range(1)));
			add_item(mlrft_pkg::CMD_EDGE, order[j], 1'($urandom_range(1)));
			if ($urandom_range(4) == 0) add_item(mlrft_pkg::CMD_EDGE, order[j], 1'b0);
			if ($urandom_range(2) == 0)
				add_item(mlrft_pkg::CMD_POLL, any_lane(), 1'($urandom_range(1)));
			if ($urandom_range(3) == 0)
				add_item(mlrft_pkg::CMD_READ, any_lane(), 1'($urandom_range(1)));
		end
		add_item(mlrft_pkg::CMD_POLL, any_lane(), 1'($urandom_range(1)));
		repeat (3) add_item(mlrft_pkg::CMD_READ, any_lane(), 1'($urandom_range(1)));
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		errors++;
		if (errors <= 30)
			$display("%0t ns: result %0d %s got %0h want %0h", $time, results_seen, what,
				got, want);
	endtask

	// lane count write, only while nothing is in flight
	task automatic write_lane_count(input logic [3:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		lanes_used = (v == 4'd0) ? 1 :
			(v > mlrft_pkg::LANES_DEF) ? mlrft_pkg::LANES_DEF : int'(v);
		cfg_writes++;
	endtask

	task automatic drain();
		while (cmd_q.size() != 0 || in_valid || timer_res_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// driver: predicts on acceptance, then offers the next item
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				timer_res_q.push_back(race_step(cur_item));
				items_taken++;
			end
			if (!in_valid || in_ready) begin
				if (cmd_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					cur_item = cmd_q.pop_front();
					in_valid <= 1'b1;
					cmd <= cur_item.cmd;
					lane <= cur_item.lane;
					gate_closed <= cur_item.gate;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: random stalls, plus a long hold-off on request
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_kick != hold_seen) begin
			hold_seen <= hold_kick;
			hold_left <= LONG_HOLD;
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= ready_stall_pct);
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (timer_res_q.size() == 0) begin
				report_mismatch("unexpected result", 32'd0, 32'd0);
			end else begin
				res_want = timer_res_q.pop_front();
				if (phase !== res_want.phase)
					report_mismatch("phase", 32'(phase), 32'(res_want.phase));
				if (accepted !== res_want.accepted)
					report_mismatch("accepted", 32'(accepted), 32'(res_want.accepted));
				if (start_time !== res_want.start_time)
					report_mismatch("start_time", start_time, res_want.start_time);
				if (lane_time !== res_want.lane_time)
					report_mismatch("lane_time", lane_time, res_want.lane_time);
				if (lane_done !== res_want.lane_done)
					report_mismatch("lane_done", 32'(lane_done), 32'(res_want.lane_done));
			end
			results_seen++;
		end
	end

	initial begin
		foreach (lane_fin[i]) lane_fin[i] = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed, lane count at reset value
		add_item(mlrft_pkg::CMD_READ, 3'd0, 1'b0);
		add_item(mlrft_pkg::CMD_ARM, 3'd0, 1'b0);
		add_item(mlrft_pkg::CMD_ARM, 3'd1, 1'b1);	// not in reset: refused
		add_item(mlrft_pkg::CMD_POLL, 3'd0, 1'b1);	// poll while set does nothing
		add_item(mlrft_pkg::CMD_TICK, 3'd0, 1'b0);
		add_item(mlrft_pkg::CMD_EDGE, 3'd7, 1'b0);	// edge before the start still records
		add_item(mlrft_pkg::CMD_GATE, 3'd7, 1'b0);	// start clears lanes
		add_item(mlrft_pkg::CMD_GATE, 3'd0, 1'b1);
		add_item(mlrft_pkg::CMD_TICK, 3'd0, 1'b0);
		add_item(mlrft_pkg::CMD_EDGE, 3'd0, 1'b0);
		add_item(mlrft_pkg::CMD_TICK, 3'd0, 1'b0);
		add_item(mlrft_pkg::CMD_EDGE, 3'd0, 1'b1);	// a repeated edge of a lane is ignored
		add_item(mlrft_pkg::CMD_EDGE, 3'd7, 1'b0);
		add_item(mlrft_pkg::CMD_POLL, 3'd7, 1'b0);	// lanes 1..6 missing
		add_item(CMD_NONE, 3'd7, 1'b1);
		add_item(mlrft_pkg::CMD_READ, 3'd7, 1'b0);
		add_item(mlrft_pkg::CMD_RESET, 3'd0, 1'b0);	// counter keeps running
		add_item(mlrft_pkg::CMD_POLL, 3'd0, 1'b0);
		add_item(mlrft_pkg::CMD_POLL, 3'd0, 1'b1);	// auto-arm
		add_item(mlrft_pkg::CMD_GATE, 3'd0, 1'b0);
		drain();

		// directed, lane count written as zero
		write_lane_count(4'd0);
		add_item(mlrft_pkg::CMD_EDGE, 3'd0, 1'b0);
		add_item(mlrft_pkg::CMD_POLL, 3'd5, 1'b0);	// one lane in use: race ends
		add_item(mlrft_pkg::CMD_POLL, 3'd0, 1'b1);
		add_item(mlrft_pkg::CMD_GATE, 3'd0, 1'b0);
		add_item(mlrft_pkg::CMD_ARM, 3'd0, 1'b0);
		drain();

		for (int p = 0; p < 6; p++) begin
			write_lane_count(4'(lane_sets[p]));
			send_idle_pct = send_rates[p];
			ready_stall_pct = ready_rates[p];
			while (cmd_q.size() < PHASE_ITEMS) begin
				if ($urandom_range(4) != 0) queue_race();
				else repeat ($urandom_range(1, 6))
					add_item(3'($urandom_range(7)), any_lane(), 1'($urandom_range(1)));
			end
			// fill the block while the output is held off
			if (p == 0) hold_kick++;
			drain();
		end

		$display("ran %0d items and checked %0d results; %0d races finished",
			items_taken, results_seen, races_done);
		$display("%0d lane count writes from 0 to 15, idle and stall rates up to 58%%",
			cfg_writes);
		if (errors == 0 && timer_res_q.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d mismatches, %0d results missing", errors, timer_res_q.size());
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/mlrft_pkg.sv
rtl/core/mlrft_core.sv
rtl/core/mlrft_outbuf.sv
rtl/core/multi_lane_race_finish_timer.sv
rtl/core/mlrft_checker.sv
sim/multi_lane_race_finish_timer_tb.sv
